FILE: src/mexp_pkg.sv
// Package for the modular exponentiation block: operand width default,
// microcode word types and the sequencer program table.
// No dependencies; used by mexp_seq and the top level of the block.
package mexp_pkg;

  localparam int OPERAND_WIDTH_DEFAULT = 32;
  localparam int FIELD_W = 32;
  localparam int STEP_W = 4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_SQUARE,
    OP_MULTIPLY,
    OP_SHIFT,
    OP_OUT,
    OP_ERR
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_MOD_ZERO,
    COND_MUL_BUSY,
    COND_BIT_ZERO,
    COND_MORE_BITS,
    COND_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic mod_zero;
    logic mul_busy;
    logic bit_zero;
    logic more_bits;
    logic out_blocked;
  } status_t;

  localparam logic [STEP_W-1:0] ST_WAIT     = 4'd0;
  localparam logic [STEP_W-1:0] ST_CHECK    = 4'd1;
  localparam logic [STEP_W-1:0] ST_INIT     = 4'd2;
  localparam logic [STEP_W-1:0] ST_REDUCE_W = 4'd3;
  localparam logic [STEP_W-1:0] ST_SQUARE   = 4'd4;
  localparam logic [STEP_W-1:0] ST_SQUARE_W = 4'd5;
  localparam logic [STEP_W-1:0] ST_TEST     = 4'd6;
  localparam logic [STEP_W-1:0] ST_MUL      = 4'd7;
  localparam logic [STEP_W-1:0] ST_MUL_W    = 4'd8;
  localparam logic [STEP_W-1:0] ST_NEXT     = 4'd9;
  localparam logic [STEP_W-1:0] ST_DONE     = 4'd10;
  localparam logic [STEP_W-1:0] ST_DONE_RET = 4'd11;
  localparam logic [STEP_W-1:0] ST_ERR      = 4'd12;
  localparam logic [STEP_W-1:0] ST_ERR_RET  = 4'd13;

  function automatic ctrl_word_t program_word(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    unique case (step)
      ST_WAIT:     w = '{OP_LOAD,     COND_NO_INPUT,    ST_WAIT};
      ST_CHECK:    w = '{OP_NONE,     COND_MOD_ZERO,    ST_ERR};
      ST_INIT:     w = '{OP_INIT,     COND_NEXT,        ST_WAIT};
      ST_REDUCE_W: w = '{OP_NONE,     COND_MUL_BUSY,    ST_REDUCE_W};
      ST_SQUARE:   w = '{OP_SQUARE,   COND_NEXT,        ST_WAIT};
      ST_SQUARE_W: w = '{OP_NONE,     COND_MUL_BUSY,    ST_SQUARE_W};
      ST_TEST:     w = '{OP_NONE,     COND_BIT_ZERO,    ST_NEXT};
      ST_MUL:      w = '{OP_MULTIPLY, COND_NEXT,        ST_WAIT};
      ST_MUL_W:    w = '{OP_NONE,     COND_MUL_BUSY,    ST_MUL_W};
      ST_NEXT:     w = '{OP_SHIFT,    COND_MORE_BITS,   ST_SQUARE};
      ST_DONE:     w = '{OP_OUT,      COND_OUT_BLOCKED, ST_DONE};
      ST_DONE_RET: w = '{OP_NONE,     COND_ALWAYS,      ST_WAIT};
      ST_ERR:      w = '{OP_ERR,      COND_OUT_BLOCKED, ST_ERR};
      ST_ERR_RET:  w = '{OP_NONE,     COND_ALWAYS,      ST_WAIT};
      default:     w = '{OP_NONE,     COND_ALWAYS,      ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

FILE: src/mexp_mulmod.sv
// Bit-serial modular multiplier: one double-and-add step with reduction
// per cycle, scanning y from its top bit. Depends on no other module.
module mexp_mulmod #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  x_hold;
  logic [W-1:0]  y_shift;
  logic [CW-1:0] cnt;
  logic [W+1:0]  sum;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W-1:0]  prod_next;

  always_comb begin
    m1  = {2'b00, m};
    m2  = {1'b0, m, 1'b0};
    sum = {1'b0, prod, 1'b0} + (y_shift[W-1] ? {2'b00, x_hold} : '0);
    if (sum >= m2) begin
      prod_next = W'(sum - m2);
    end else if (sum >= m1) begin
      prod_next = W'(sum - m1);
    end else begin
      prod_next = W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_hold  <= x;
      y_shift <= y;
      prod    <= '0;
      cnt     <= CW'(W - 1);
    end else if (busy) begin
      prod    <= prod_next;
      y_shift <= {y_shift[W-2:0], 1'b0};
      cnt     <= cnt - 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("Multiplier finished without running.");
  assert property (@(posedge clk) disable iff (rst) busy |-> prod < m || m == '0)
    else $error("Partial product left the residue range.");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Multiplier busy while reporting completion.");

endmodule

FILE: src/mexp_seq.sv
// Microcode sequencer: step counter over the program table in the package,
// with conditional jumps on datapath status. Depends on mexp_pkg.
module mexp_seq (
  input  logic                clk,
  input  logic                rst,
  input  mexp_pkg::status_t   status,
  output mexp_pkg::ctrl_word_t ctrl
);

  import mexp_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take;

  always_comb begin
    ctrl = program_word(step);
    case (ctrl.cond)
      COND_NEXT:        take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_INPUT:    take = !status.in_valid;
      COND_MOD_ZERO:    take = status.mod_zero;
      COND_MUL_BUSY:    take = status.mul_busy;
      COND_BIT_ZERO:    take = status.bit_zero;
      COND_MORE_BITS:   take = status.more_bits;
      COND_OUT_BLOCKED: take = status.out_blocked;
      default:          take = 1'b0;
    endcase
    step_next = take ? ctrl.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: src/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: stream ports, operand
// registers and output register. Depends on mexp_pkg, mexp_seq, mexp_mulmod.
//
//   channel  | direction | tdata                              | tuser
//   s_axis   | in        | base, exponent, modulus (32 each)  | none
//   m_axis   | out       | power_result (32)                  | zero_modulus_error
//
// A request's run time for operand width W is set by the bit-serial modular
// multiplier: one reduction product, then for each of the W exponent bits a
// square and, for each one bit, a multiply. A zero modulus is answered
// without starting the multiplier. Reset is synchronous and clears the
// sequencer, the multiplier's busy and done flags and the output valid flag.
// A stalled result holds in the output register while the block takes and
// works on the next request.
module modular_exponentiation_top #(
  parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // base_value [31:0], exponent_value [63:32], modulus_value [95:64]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // power_result [31:0]
  output logic [31:0] m_axis_tdata,
  // zero_modulus_error [0]
  output logic        m_axis_tuser
);

  import mexp_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int XW = (W > FIELD_W) ? W : FIELD_W;
  localparam int BW = $clog2(W + 1);

  ctrl_word_t     ctrl;
  status_t        status;
  logic [W-1:0]   base;
  logic [W-1:0]   expo;
  logic [W-1:0]   modulus;
  logic [W-1:0]   acc;
  logic [BW-1:0]  bit_cnt;
  logic           dest_base;
  logic [W-1:0]   one_mod;
  logic [W-1:0]   mul_x;
  logic [W-1:0]   mul_y;
  logic           mul_start;
  logic           mul_busy;
  logic           mul_done;
  logic [W-1:0]   prod;
  logic [XW-1:0]  base_ext;
  logic [XW-1:0]  expo_ext;
  logic [XW-1:0]  mod_ext;
  logic [XW-1:0]  acc_ext;
  logic           accept;

  assign base_ext = XW'(s_axis_tdata[31:0]);
  assign expo_ext = XW'(s_axis_tdata[63:32]);
  assign mod_ext  = XW'(s_axis_tdata[95:64]);
  assign acc_ext  = XW'(acc);

  assign s_axis_tready = (ctrl.op == OP_LOAD);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign one_mod       = W'(modulus != W'(1));

  always_comb begin
    status.in_valid    = s_axis_tvalid;
    status.mod_zero    = (modulus == '0);
    status.mul_busy    = mul_busy;
    status.bit_zero    = !expo[W-1];
    status.more_bits   = (bit_cnt != BW'(1));
    status.out_blocked = m_axis_tvalid && !m_axis_tready;
  end

  always_comb begin
    mul_start = 1'b0;
    mul_x     = acc;
    mul_y     = acc;
    case (ctrl.op)
      OP_INIT: begin
        mul_start = 1'b1;
        mul_x     = one_mod;
        mul_y     = base;
      end
      OP_SQUARE: begin
        mul_start = 1'b1;
      end
      OP_MULTIPLY: begin
        mul_start = 1'b1;
        mul_x     = base;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  mexp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  mexp_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (modulus),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      base    <= base_ext[W-1:0];
      expo    <= expo_ext[W-1:0];
      modulus <= mod_ext[W-1:0];
      bit_cnt <= BW'(W);
    end else if (ctrl.op == OP_SHIFT) begin
      expo    <= {expo[W-2:0], 1'b0};
      bit_cnt <= bit_cnt - 1'b1;
    end
    if (ctrl.op == OP_INIT) begin
      acc       <= one_mod;
      dest_base <= 1'b1;
    end else if (ctrl.op == OP_SQUARE || ctrl.op == OP_MULTIPLY) begin
      dest_base <= 1'b0;
    end
    if (mul_done) begin
      if (dest_base) begin
        base <= prod;
      end else begin
        acc <= prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (ctrl.op == OP_OUT && !status.out_blocked) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= acc_ext[FIELD_W-1:0];
        m_axis_tuser  <= 1'b0;
      end else if (ctrl.op == OP_ERR && !status.out_blocked) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= '0;
        m_axis_tuser  <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) s_axis_tready |-> !mul_busy)
    else $error("Request taken while a product is in progress.");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("Zero-modulus result carries nonzero data.");
  assert property (@(posedge clk) disable iff (rst)
    mul_done |-> ctrl.cond == COND_MUL_BUSY)
    else $error("Product completed outside a wait step.");
  assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy && !status.mod_zero)
    else $error("Product started while busy or with a zero modulus.");

endmodule

FILE: verif/mexp_checker.sv
`timescale 1ns / 1ps
// Checker for the modular exponentiation block: watches both stream channels,
// predicts each power from the accepted request and compares it in order.
// Standalone; needs only the channel signals of modular_exponentiation_top.
module mexp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [31:0] power;
    logic        zero_mod;
  } power_result_t;

  power_result_t expected_powers[$];

  function automatic power_result_t power_mod(input logic [31:0] base,
                                              input logic [31:0] expo,
                                              input logic [31:0] modulus);
    power_result_t r;
    logic [63:0]   acc;
    logic [63:0]   reduced;
    logic [63:0]   m64;
    r.power    = '0;
    r.zero_mod = 1'b1;
    if (modulus == 32'd0) begin
      return r;
    end
    m64     = {32'd0, modulus};
    reduced = {32'd0, base} % m64;
    acc     = 64'd1 % m64;
    for (int i = 31; i >= 0; i--) begin
      acc = (acc * acc) % m64;
      if (expo[i]) begin
        acc = (acc * reduced) % m64;
      end
    end
    r.power    = acc[31:0];
    r.zero_mod = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    power_result_t want;
    int            errs;
    int            delta;
    if (rst) begin
      fail_count    <= 0;
      pending_count <= 0;
      expected_powers.delete();
    end else begin
      errs  = 0;
      delta = 0;
      if (m_tvalid && m_tready) begin
        if (expected_powers.size() == 0) begin
          $error("unexpected result: power_result %h, zero_modulus_error %b",
                 m_tdata, m_tuser);
          errs++;
        end else begin
          want = expected_powers.pop_front();
          delta--;
          if (m_tdata !== want.power) begin
            $error("power_result: expected %h, actual %h", want.power, m_tdata);
            errs++;
          end
          if (m_tuser !== want.zero_mod) begin
            $error("zero_modulus_error: expected %b, actual %b", want.zero_mod, m_tuser);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_powers.insert(expected_powers.size(),
                               power_mod(s_tdata[31:0], s_tdata[63:32],
                                         s_tdata[95:64]));
        delta++;
      end
      fail_count    <= fail_count + errs;
      pending_count <= pending_count + delta;
    end
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the modular exponentiation testbench: clock, reset, request stimulus,
// result backpressure, watchdog and verdict. Depends on mexp_checker and the block.
module testbench;

  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 6000;
  localparam int TAIL_CYCLES = 3000;
  localparam int PHASE_ITEMS = 87;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count;
  int pending_count;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_cycles;
  bit hold_req;

  modular_exponentiation_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mexp_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_axis_tvalid),
    .s_tready      (s_axis_tready),
    .s_tdata       (s_axis_tdata),
    .m_tvalid      (m_axis_tvalid),
    .m_tready      (m_axis_tready),
    .m_tdata       (m_axis_tdata),
    .m_tuser       (m_axis_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit hold_served;
    hold_served = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(input logic [31:0] base, input logic [31:0] expo,
                              input logic [31:0] modulus);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {modulus, expo, base};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_random;
    logic [31:0] a;
    logic [31:0] k;
    logic [31:0] m;
    int          kind;
    a    = $urandom;
    k    = $urandom;
    m    = $urandom;
    kind = $urandom_range(0, 19);
    case (kind)
      10, 11: m = $urandom_range(1, 255);
      12:     m = m | 32'h8000_0000;
      13:     m = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'd1;
      14:     k = $urandom_range(0, 3);
      15:     a = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'd1;
      16:     a = m - 32'd1;
      17:     m = 32'd1 << $urandom_range(0, 31);
      18:     a = 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: ;
    endcase
    if (m == 32'd0 && kind != 13) begin
      m = 32'd3;
    end
    send_request(a, k, m);
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    send_idle_pct  = 12;
    recv_idle_pct  = 67;
    hold_req       = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(32'd0, 32'd0, 32'd0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_request(32'd5, 32'd3, 32'd0);
    send_request(32'd7, 32'd0, 32'd13);
    send_request(32'd7, 32'd0, 32'd1);
    send_request(32'd0, 32'd0, 32'd5);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_request(32'd123, 32'd456, 32'd1);
    send_request(32'd2, 32'd10, 32'd1000);
    send_request(32'd0, 32'd5, 32'd7);
    send_request(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE);
    send_request(32'd3, 32'h8000_0000, 32'hFFFF_FFFB);
    send_request(32'd3, 32'd1, 32'd7);
    send_request(32'd100, 32'd1, 32'd7);
    send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
    send_request(32'd2, 32'd32, 32'h8000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
    send_request(32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_FFC5);

    hold_req = 1'b1;
    repeat (PHASE_ITEMS) send_random();

    send_idle_pct = 67;
    recv_idle_pct = 12;
    repeat (PHASE_ITEMS) send_random();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PHASE_ITEMS) send_random();

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
